FILE: src/pidl_pkg.sv
// ----------------------------------------------------------------------------
// pidl_pkg
// Shared types and constants for the positional insert/delete list.
// ----------------------------------------------------------------------------
package pidl_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int MODE_W  = 2;
    localparam int POS_W   = 5;
    localparam int ITEM_W  = 32;
    localparam int COUNT_W = 5;

    // index width large enough for any supported depth (up to 1024)
    localparam int IDX_W = 11;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_READ   = 2'd2
    } t_mode;

    typedef struct packed {
        logic             ins;
        logic             del;
        logic [IDX_W-1:0] pos;
    } t_cell_ctrl;

endpackage

FILE: src/pidl_cell.sv
// ----------------------------------------------------------------------------
// pidl_cell
// One list slot. Takes a new word, its lower neighbor's word on insert, or
// its upper neighbor's word on delete; presents its word when addressed.
// ----------------------------------------------------------------------------
module pidl_cell #(
    parameter int IDX        = 0,
    parameter int DATA_WIDTH = pidl_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  pidl_pkg::t_cell_ctrl  i_ctrl,
    input  logic [DATA_WIDTH-1:0] i_word,
    input  logic [DATA_WIDTH-1:0] i_below,
    input  logic [DATA_WIDTH-1:0] i_above,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [DATA_WIDTH-1:0] o_rd
);

    localparam logic [pidl_pkg::IDX_W-1:0] MY_IDX = pidl_pkg::IDX_W'(IDX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  w_hit;
    logic                  w_after;

    assign w_hit   = (i_ctrl.pos == MY_IDX);
    assign w_after = (MY_IDX > i_ctrl.pos);

    always_comb begin
        n_data = r_data;
        if (i_ctrl.ins) begin
            if (w_hit) begin
                n_data = i_word;
            end else if (w_after) begin
                n_data = i_below;
            end
        end else if (i_ctrl.del) begin
            if (w_hit || w_after) begin
                n_data = i_above;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_rd   = w_hit ? r_data : '0;

endmodule

FILE: src/positional_insert_delete_list.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_list_core
// Bounded ordered list with insert, delete and read at a position.
//
// A transaction is accepted on a rising edge with start high and busy low.
// busy never rises: a new transaction may be issued every cycle.
// i_mode selects insert, delete or read; i_position is the target index;
// i_item_value is the word stored by an insert.
// In the cycle after acceptance o_valid pulses for one cycle with
// o_status (0 ok, 1 full / empty / out of range), o_read_value (read data,
// else zero) and o_entry_count (entries held after the transaction).
// Throughput 1 transaction per cycle: every slot is a cell
// that compares its index with the clamped position and shifts in parallel,
// and the read word is an OR over all cells' addressed outputs.
// The receiver cannot stall; results must be taken as they appear.
// Reset empties the list; slot contents are not cleared and are never read
// before being written.
// ----------------------------------------------------------------------------
module positional_insert_delete_list_core #(
    parameter int DEPTH      = pidl_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = pidl_pkg::DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [pidl_pkg::MODE_W-1:0]  i_mode,
    input  logic [pidl_pkg::POS_W-1:0]   i_position,
    input  logic [pidl_pkg::ITEM_W-1:0]  i_item_value,
    output logic                         o_valid,
    output logic                         o_status,
    output logic [pidl_pkg::ITEM_W-1:0]  o_read_value,
    output logic [pidl_pkg::COUNT_W-1:0] o_entry_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = pidl_pkg::IDX_W;
    localparam int XW = (DATA_WIDTH > pidl_pkg::ITEM_W) ? DATA_WIDTH : pidl_pkg::ITEM_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_valid;
    logic                  r_status;
    logic [XW-1:0]         r_read_x;

    logic [IW-1:0]         w_pos;
    logic [IW-1:0]         w_cnt;
    logic [IW-1:0]         w_last;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_ins_ok;
    logic                  w_del_ok;
    logic                  w_rd_ok;
    logic [XW-1:0]         w_item_x;
    logic [DATA_WIDTH-1:0] w_word;
    logic [DATA_WIDTH-1:0] w_rd_or;
    pidl_pkg::t_cell_ctrl  w_ctrl;

    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic [DATA_WIDTH-1:0] w_rd   [DEPTH];

    assign w_pos    = IW'(i_position);
    assign w_cnt    = IW'(r_count);
    assign w_last   = w_cnt - IW'(1);
    assign w_full   = (r_count == FULL_CNT);
    assign w_empty  = (r_count == '0);
    assign w_item_x = XW'(i_item_value);
    assign w_word   = w_item_x[DATA_WIDTH-1:0];

    assign w_ins_ok = start && (i_mode == pidl_pkg::MODE_INSERT) && !w_full;
    assign w_del_ok = start && (i_mode == pidl_pkg::MODE_DELETE) && !w_empty;
    assign w_rd_ok  = (i_mode == pidl_pkg::MODE_READ) && (w_pos < w_cnt);

    always_comb begin
        w_ctrl.ins = w_ins_ok;
        w_ctrl.del = w_del_ok;
        w_ctrl.pos = w_pos;
        if (i_mode == pidl_pkg::MODE_INSERT) begin
            w_ctrl.pos = (w_pos > w_cnt) ? w_cnt : w_pos;
        end else if (i_mode == pidl_pkg::MODE_DELETE) begin
            w_ctrl.pos = (w_pos > w_last) ? w_last : w_pos;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_below;
            logic [DATA_WIDTH-1:0] w_above;
            if (g == 0) begin : g_first
                assign w_below = w_word;
            end else begin : g_mid_lo
                assign w_below = w_data[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_above = w_data[g];
            end else begin : g_mid_hi
                assign w_above = w_data[g+1];
            end
            pidl_cell #(
                .IDX        (g),
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_word  (w_word),
                .i_below (w_below),
                .i_above (w_above),
                .o_data  (w_data[g]),
                .o_rd    (w_rd[g])
            );
        end
    endgenerate

    always_comb begin
        w_rd_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rd_or = w_rd_or | w_rd[k];
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_ins_ok) begin
            n_count = r_count + CW'(1);
        end else if (w_del_ok) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= start;
        end
        r_status <= !(w_ins_ok || w_del_ok || w_rd_ok);
        r_read_x <= (start && w_rd_ok) ? XW'(w_rd_or) : '0;
    end

    assign busy          = 1'b0;
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_read_value  = r_read_x[pidl_pkg::ITEM_W-1:0];
    assign o_entry_count = pidl_pkg::COUNT_W'(r_count);

    a_start_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> o_valid)
        else $error("accepted transaction produced no result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_mode == pidl_pkg::MODE_INSERT && !w_full)
        |=> (o_valid && !o_status && r_count == CW'($past(r_count) + CW'(1))))
        else $error("insert did not add one entry");

    a_error_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !w_ins_ok && !w_del_ok) |=> (r_count == $past(r_count)))
        else $error("count changed without insert or delete");

endmodule
